// File: hw/rtl/cng_pkg.sv
// Shared constants and types for the comfort noise generator.
package cng_pkg;

  localparam int HIST_DEPTH = 7;
  localparam int NUM_COEF   = 4;

  localparam logic signed [31:0] LP_COEF [NUM_COEF] = '{
    32'sd115, 32'sd373, 32'sd961, 32'sd1440
  };

  localparam logic [31:0] INIT_LEVEL_RST = 32'd1000;
  localparam logic [31:0] LOW_THR_RST    = 32'd6000;
  localparam logic [31:0] HIGH_THR_RST   = 32'd12000;

  localparam logic [1:0] REG_INIT_LEVEL = 2'd0;
  localparam logic [1:0] REG_LOW_THR    = 2'd1;
  localparam logic [1:0] REG_HIGH_THR   = 2'd2;

  typedef logic [1:0] shift_sel_t;
  localparam shift_sel_t SHIFT_25 = 2'd0;
  localparam shift_sel_t SHIFT_24 = 2'd1;
  localparam shift_sel_t SHIFT_23 = 2'd2;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [5:0]  noise_t;

  localparam int OUT_W = 40;

endpackage

// File: hw/rtl/cng_fir.sv
// Eight-tap symmetric lowpass filter with its sample history and output scaling.
module cng_fir (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  cng_pkg::sample_t    sample,
  input  cng_pkg::shift_sel_t shift_sel,
  output cng_pkg::noise_t     noise
);
  import cng_pkg::*;

  sample_t            hist_r [HIST_DEPTH];
  sample_t            taps   [HIST_DEPTH + 1];
  logic signed [31:0] prod   [NUM_COEF];
  logic signed [16:0] pair   [NUM_COEF];
  logic signed [31:0] acc;

  always_comb begin
    taps[0] = sample;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      taps[i + 1] = hist_r[i];
    end
    acc = '0;
    for (int k = 0; k < NUM_COEF; k++) begin
      pair[k] = 17'(taps[k]) + 17'(taps[HIST_DEPTH - k]);
      prod[k] = 32'(pair[k]) * LP_COEF[k];
      acc     = acc + prod[k];
    end
  end

  always_comb begin
    case (shift_sel)
      SHIFT_25: noise = acc[30:25];
      SHIFT_24: noise = acc[29:24];
      SHIFT_23: noise = acc[28:23];
      default:  noise = acc[30:25];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (shift_en) begin
      hist_r[0] <= sample;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i - 1];
      end
    end
  end

endmodule

// File: hw/rtl/cng_obuf.sv
// Two-entry result buffer: an output register backed by a skid register.
module cng_obuf #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         out_valid_r;
  logic [W-1:0] out_data_r;
  logic         skid_valid_r;
  logic [W-1:0] skid_data_r;
  logic         load;
  logic         out_free;

  assign in_ready  = !skid_valid_r;
  assign load      = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= load;
      end
    end else if (load) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (load) begin
        out_data_r <= in_data;
      end
    end else if (load) begin
      skid_data_r <= in_data;
    end
  end

endmodule

// File: hw/rtl/comfort_noise_generator_unit.sv
// Top level of the comfort noise generator with background level tracking.
//
// Input transactions carry one sample on in_tdata. in_tuser selects the
// mode: low measures a speech sample, high turns the sample, taken as a raw
// white-noise value, into one comfort noise sample. in_tlast marks the last
// speech sample of a frame, where the tracked noise level is updated.
// Every input transaction yields exactly one output transaction holding the
// scaled filter output (zero in measure mode) and the tracked level.
// The result is registered, and one transaction can be accepted every cycle
// while the skid register is empty. The filter and the level update
// are evaluated in the cycle of acceptance.
// When the receiver stalls, one further result is held in a skid register,
// after which in_tready drops until the output drains.
// Reset clears the filter history and the frame sum, restores the register
// defaults and loads the tracked level with the reset default of the initial level.
// A write to the initial level register reloads the tracked level at once.
module comfort_noise_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tuser,   // [0] mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] noise_out, [37:6] noise_level, [39:38] zero
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import cng_pkg::*;

  logic [31:0] low_thr_r;
  logic [31:0] high_thr_r;
  logic [31:0] sum_r;
  logic [31:0] level_r;
  logic [31:0] sum_nxt;
  logic [31:0] level_nxt;

  logic        accept;
  logic        gen;
  sample_t     sample;
  logic [16:0] sample_ext;
  logic [16:0] mag;
  logic [31:0] sum_add;
  logic [31:0] twice;
  logic [31:0] mix;
  shift_sel_t  shift_sel;
  noise_t      fir_noise;
  noise_t      noise_out;
  logic [OUT_W-1:0] result;

  assign accept     = in_tvalid && in_tready;
  assign gen        = in_tuser;
  assign sample     = in_tdata;
  assign sample_ext = {sample[15], sample};
  assign mag        = sample[15] ? (17'd0 - sample_ext) : sample_ext;
  assign sum_add    = sum_r + {15'd0, mag};
  assign twice      = {level_r[30:0], 1'b0};
  assign mix        = sum_add + {level_r[26:0], 5'd0} - level_r;

  always_comb begin
    if (level_r < low_thr_r) begin
      shift_sel = SHIFT_25;
    end else if (level_r < high_thr_r) begin
      shift_sel = SHIFT_24;
    end else begin
      shift_sel = SHIFT_23;
    end
  end

  always_comb begin
    sum_nxt   = sum_r;
    level_nxt = level_r;
    if (accept && !gen) begin
      if (in_tlast) begin
        sum_nxt = '0;
        if (sum_add < twice) begin
          level_nxt = {5'd0, mix[31:5]};
        end
      end else begin
        sum_nxt = sum_add;
      end
    end
  end

  cng_fir u_fir (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (accept && gen),
    .sample    (sample),
    .shift_sel (shift_sel),
    .noise     (fir_noise)
  );

  assign noise_out = gen ? fir_noise : '0;
  assign result    = {2'd0, level_nxt, noise_out};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r    <= LOW_THR_RST;
      high_thr_r   <= HIGH_THR_RST;
      level_r      <= INIT_LEVEL_RST;
      sum_r        <= '0;
    end else begin
      sum_r   <= sum_nxt;
      level_r <= level_nxt;
      if (cfg_wen) begin
        case (cfg_index)
          REG_INIT_LEVEL: level_r <= cfg_wdata;
          REG_LOW_THR:  low_thr_r  <= cfg_wdata;
          REG_HIGH_THR: high_thr_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  cng_obuf #(
    .W (OUT_W)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (result),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// File: hw/rtl/cng_checker.sv
// Port-level checks for the comfort noise generator, bound to the top level.
module cng_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output transaction dropped while stalled");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> out_tvalid)
    else $error("accepted transaction did not produce a result");

  a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[5:0]) >= -6'sd23 && $signed(out_tdata[5:0]) <= 6'sd22))
    else $error("noise sample out of range");

  a_measure_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> out_tdata[5:0] == 6'd0)
    else $error("measure transaction produced nonzero noise");

endmodule

bind comfort_noise_generator_unit cng_checker u_cng_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/testbench.sv
// Self-checking testbench for the comfort noise generator, with a built-in predictor.
module testbench;
  import cng_pkg::*;

  typedef struct packed {
    noise_t      noise;
    logic [31:0] level;
  } cng_result_t;

  typedef struct packed {
    logic        mode;
    sample_t     smp;
    logic        last;
    logic        typed;
    noise_t      exp_noise;
    logic [31:0] exp_level;
  } dir_row_t;

  localparam int LPF_TAPS [4] = '{115, 373, 961, 1440};
  localparam int NUM_DIR = 25;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES = 8;

  localparam dir_row_t DIRECTED [NUM_DIR] = '{
    '{1'b0, 16'sh0000, 1'b0, 1'b1, 6'sd0, 32'd1000},
    '{1'b0, 16'sh8000, 1'b0, 1'b1, 6'sd0, 32'd1000},
    '{1'b0, 16'sh7FFF, 1'b1, 1'b1, 6'sd0, 32'd1000},
    '{1'b0, 16'sh0064, 1'b1, 1'b1, 6'sd0, 32'd971},
    '{1'b0, 16'shFF9C, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b0, 16'sh0000, 1'b1, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b1, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh8000, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh0000, 1'b1, 1'b0, 6'sd0, 32'd0},
    '{1'b1, 16'sh5555, 1'b0, 1'b0, 6'sd0, 32'd0},
    '{1'b0, 16'shAAAA, 1'b1, 1'b0, 6'sd0, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = REG_INIT_LEVEL;
  logic [31:0] cfg_wdata = '0;

  sample_t     noise_hist [HIST_DEPTH];
  logic [31:0] frame_sum;
  logic [31:0] level_model;
  logic [31:0] low_thr_reg;
  logic [31:0] high_thr_reg;

  cng_result_t expected_results [$];
  cng_result_t want_result;
  int          n_fail = 0;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  logic        hold_req = 1'b0;

  comfort_noise_generator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void reset_model();
    int i;
    for (i = 0; i < HIST_DEPTH; i++) noise_hist[i] = '0;
    frame_sum      = '0;
    low_thr_reg    = LOW_THR_RST;
    high_thr_reg   = HIGH_THR_RST;
    level_model    = INIT_LEVEL_RST;
  endfunction

  function automatic cng_result_t predict_noise(input logic mode, input sample_t smp,
                                                input logic last);
    cng_result_t r;
    longint      acc;
    int          taps [8];
    int          xi;
    int          i;
    logic [31:0] mag;
    logic [31:0] twice;
    logic [31:0] mixed;
    r.noise = '0;
    xi = smp;
    if (mode) begin
      taps[0] = xi;
      for (i = 0; i < HIST_DEPTH; i++) taps[i + 1] = noise_hist[i];
      acc = 0;
      for (i = 0; i < 4; i++) acc += longint'(LPF_TAPS[i]) * longint'(taps[i] + taps[7 - i]);
      if (level_model < low_thr_reg) acc = acc >>> 25;
      else if (level_model < high_thr_reg) acc = acc >>> 24;
      else acc = acc >>> 23;
      r.noise = acc[5:0];
      for (i = HIST_DEPTH - 1; i > 0; i--) noise_hist[i] = noise_hist[i - 1];
      noise_hist[0] = smp;
    end else begin
      mag = (xi < 0) ? -xi : xi;
      frame_sum = frame_sum + mag;
      if (last) begin
        twice = level_model << 1;
        if (frame_sum < twice) begin
          mixed = frame_sum + level_model * 32'd31;
          level_model = mixed >> 5;
        end
        frame_sum = '0;
      end
    end
    r.level = level_model;
    return r;
  endfunction

  task automatic send_item(input logic mode, input sample_t smp, input logic last,
                           input logic typed, input noise_t t_noise,
                           input logic [31:0] t_level);
    int          gap;
    cng_result_t r;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= smp;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    r = predict_noise(mode, smp, last);
    if (typed) begin
      r.noise = t_noise;
      r.level = t_level;
    end
    expected_results.push_back(r);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] lvl, input logic [31:0] lo,
                            input logic [31:0] hi);
    logic [1:0]  codes [3];
    logic [1:0]  tmp;
    logic [31:0] v;
    int          k;
    int          j;
    codes = '{REG_INIT_LEVEL, REG_LOW_THR, REG_HIGH_THR};
    for (k = 2; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = codes[k];
      codes[k] = codes[j];
      codes[j] = tmp;
    end
    for (k = 0; k < 3; k++) begin
      case (codes[k])
        REG_INIT_LEVEL: v = lvl;
        REG_LOW_THR:    v = lo;
        default:        v = hi;
      endcase
      cfg_wen   <= 1'b1;
      cfg_index <= codes[k];
      cfg_wdata <= v;
      @(posedge clk);
      case (codes[k])
        REG_INIT_LEVEL: level_model = v;
        REG_LOW_THR:    low_thr_reg = v;
        default:        high_thr_reg = v;
      endcase
    end
    cfg_wen <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int      done;
    int      kind;
    int      len;
    int      j;
    int      amp;
    longint  cap;
    logic    full;
    sample_t s;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len  = $urandom_range(1, 12);
        cap  = (longint'(level_model) * 2) / len;
        if (cap > 32767) cap = 32767;
        full = ($urandom_range(0, 4) == 0);
        for (j = 0; j < len; j++) begin
          if (full) begin
            s = sample_t'($urandom);
          end else begin
            amp = $urandom_range(0, int'(cap));
            s = $urandom_range(0, 1) ? sample_t'(-amp) : sample_t'(amp);
          end
          send_item(1'b0, s, j == len - 1, 1'b0, '0, '0);
        end
        done += len;
      end else if (kind < 90) begin
        len = $urandom_range(1, 8);
        for (j = 0; j < len; j++)
          send_item(1'b1, sample_t'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0, '0);
        done += len;
      end else begin
        send_item(1'($urandom_range(0, 1)), sample_t'($urandom), 1'($urandom_range(0, 1)),
                  1'b0, '0, '0);
        done += 1;
      end
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rx_calm) begin
        out_tready <= 1'b1;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("output transaction with no expected result: tdata %h", out_tdata);
        n_fail++;
      end else begin
        want_result = expected_results.pop_front();
        if (out_tdata[5:0] !== want_result.noise) begin
          $error("noise_out expected %0d actual %0d", want_result.noise,
                 $signed(out_tdata[5:0]));
          n_fail++;
        end
        if (out_tdata[37:6] !== want_result.level) begin
          $error("noise_level expected %0d actual %0d", want_result.level, out_tdata[37:6]);
          n_fail++;
        end
        if (out_tdata[39:38] !== 2'b00) begin
          $error("pad expected 0 actual %0d", out_tdata[39:38]);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int p;
    int i;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        case (p)
          1: set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
          2: set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          3: set_config(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
          default: begin
            i = $urandom_range(0, 15000);
            set_config($urandom_range(0, 20000), i, i + $urandom_range(0, 15000));
          end
        endcase
      end
      tx_calm = (p == 1) || (p == 3) || (p == 6);
      rx_calm = (p == 3) || (p == 6);
      if (p == 0) begin
        for (i = 0; i < NUM_DIR; i++)
          send_item(DIRECTED[i].mode, DIRECTED[i].smp, DIRECTED[i].last, DIRECTED[i].typed,
                    DIRECTED[i].exp_noise, DIRECTED[i].exp_level);
      end
      if (p == 1) hold_req = 1'b1;
      run_random(ITEMS_PER_PHASE);
    end
    drain_results();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cng_pkg.sv
hw/rtl/cng_fir.sv
hw/rtl/cng_obuf.sv
hw/rtl/comfort_noise_generator_unit.sv
hw/rtl/cng_checker.sv
dv/testbench.sv
